// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a condition on every rising clock edge outside reset.
`define HSV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle that implies a consequence in the next cycle.
`define HSV_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB package
// Widths and fixed-point constants of the HSV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

	// Field widths and formats.
	localparam int CH_FRAC  = 15;
	localparam int CH_W     = 16;
	localparam int HUE_W    = 17;
	localparam int HUE_FRAC = 6;

	localparam logic [CH_W-1:0] CH_ONE = CH_W'(1 << CH_FRAC);

	// One sector is 60 degrees, one turn is six sectors.
	localparam int SPAN_INT   = 60 << HUE_FRAC;
	localparam int PERIOD_INT = 6 * SPAN_INT;

	// Biased hue: hue plus three turns, never negative.
	localparam int U_W = 18;
	localparam int R_W = 15;
	localparam int F_W = 12;

	localparam logic [U_W-1:0] HUE_BIAS = U_W'(3 * PERIOD_INT);
	localparam logic [U_W-1:0] PERIOD_1 = U_W'(1 * PERIOD_INT);
	localparam logic [U_W-1:0] PERIOD_2 = U_W'(2 * PERIOD_INT);
	localparam logic [U_W-1:0] PERIOD_3 = U_W'(3 * PERIOD_INT);
	localparam logic [U_W-1:0] PERIOD_4 = U_W'(4 * PERIOD_INT);
	localparam logic [U_W-1:0] PERIOD_5 = U_W'(5 * PERIOD_INT);

	localparam logic [R_W-1:0] SPAN_1 = R_W'(1 * SPAN_INT);
	localparam logic [R_W-1:0] SPAN_2 = R_W'(2 * SPAN_INT);
	localparam logic [R_W-1:0] SPAN_3 = R_W'(3 * SPAN_INT);
	localparam logic [R_W-1:0] SPAN_4 = R_W'(4 * SPAN_INT);
	localparam logic [R_W-1:0] SPAN_5 = R_W'(5 * SPAN_INT);

	localparam logic [F_W-1:0] SPAN_F = F_W'(SPAN_INT);

	// Division by the sector span: span = 15 * 2^8, the factor of 15 is
	// taken by a reciprocal multiply that is exact for dividends below 2^19.
	localparam int VS_W        = 2 * CH_W;
	localparam int CN_W        = 27;
	localparam int DIV_SHIFT   = 8;
	localparam int A_W         = CN_W - DIV_SHIFT;
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 23;
	localparam int Q_W         = A_W + RECIP_W;

	localparam logic [VS_W-1:0]    VS_HALF   = VS_W'(1 << (CH_FRAC - 1));
	localparam logic [CN_W-1:0]    SPAN_HALF = CN_W'(SPAN_INT / 2);
	localparam logic [RECIP_W-1:0] RECIP_15  = RECIP_W'(559241);

	// Sector codes.
	localparam logic [2:0] SECTOR_RED_GREEN   = 3'd0;
	localparam logic [2:0] SECTOR_GREEN_RED   = 3'd1;
	localparam logic [2:0] SECTOR_GREEN_BLUE  = 3'd2;
	localparam logic [2:0] SECTOR_BLUE_GREEN  = 3'd3;
	localparam logic [2:0] SECTOR_BLUE_RED    = 3'd4;
	localparam logic [2:0] SECTOR_RED_BLUE    = 3'd5;

	typedef logic [CH_W-1:0] chan_t;

endpackage

`default_nettype wire

// ----- rtl/hsv_pix_if.sv -----
// ----------------------------------------------------------------------------
// HSV pixel channel
// Valid/ready stream carrying one HSV pixel per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsv_pix_if import hsv2rgb_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [HUE_W-1:0] hue;
	logic [CH_W-1:0]         saturation;
	logic [CH_W-1:0]         brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/rgb_pix_if.sv -----
// ----------------------------------------------------------------------------
// RGB pixel channel
// Valid/ready stream carrying one RGB pixel per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgb_pix_if import hsv2rgb_pkg::*;;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ----- rtl/hsv_to_rgb_converter_top.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Six-stage pipeline that turns one HSV pixel into one RGB pixel.
// ----------------------------------------------------------------------------
// Usage:
// The hsv channel takes hue (signed degrees, 6 fraction bits), saturation and
// brightness (Q1.15, values above 1.0 clamp to 1.0). The rgb channel returns
// red, green and blue in Q1.15, one result for every input transfer, in order.
// A pixel taken on the hsv channel passes through the register stages in order
// before it can leave on the rgb channel. One pixel is taken in every clock
// cycle unless a stall holds hsv.ready low; the rate is set by the six register
// stages, each holding one pixel (clamp and hue bias, chroma multiply and hue
// reduction, sector split, secondary multiply, reciprocal divide, channel mix).
// When the receiver holds ready low, the output stage keeps its result and
// earlier stages keep filling until every stage holds a pixel; only then does
// hsv.ready fall. Nothing is dropped or duplicated across a stall.
// Reset clears all valid bits, so the pipeline comes up empty; pixel data
// registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_top import hsv2rgb_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	hsv_pix_if.sink    hsv,
	rgb_pix_if.source  rgb
);

	`include "assert_macros.svh"

	// Stage valid bits and per-stage advance enables.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	assign en_s6 = !valid_s6 || rgb.ready;
	assign en_s5 = !valid_s5 || en_s6;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;

	assign hsv.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= hsv.valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_s6) valid_s6 <= valid_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: clamp saturation and value, bias hue to a positive number.
	// ------------------------------------------------------------------
	chan_t          sat_s1, val_s1;
	logic [U_W-1:0] hue_u_s1;
	logic [U_W-1:0] hue_u_next;

	assign hue_u_next = U_W'($signed(hsv.hue)) + HUE_BIAS;

	always_ff @(posedge clk) begin
		if (en_s1 && hsv.valid) begin
			sat_s1   <= (hsv.saturation > CH_ONE) ? CH_ONE : hsv.saturation;
			val_s1   <= (hsv.brightness > CH_ONE) ? CH_ONE : hsv.brightness;
			hue_u_s1 <= hue_u_next;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: V*S, and hue reduced into one turn.
	// ------------------------------------------------------------------
	logic [VS_W-1:0] vs_s2;
	chan_t           val_s2;
	logic [R_W-1:0]  hue_r_s2;
	logic [U_W-1:0]  hue_red;

	always_comb begin
		priority if (hue_u_s1 >= PERIOD_5) hue_red = hue_u_s1 - PERIOD_5;
		else if (hue_u_s1 >= PERIOD_4)     hue_red = hue_u_s1 - PERIOD_4;
		else if (hue_u_s1 >= PERIOD_3)     hue_red = hue_u_s1 - PERIOD_3;
		else if (hue_u_s1 >= PERIOD_2)     hue_red = hue_u_s1 - PERIOD_2;
		else if (hue_u_s1 >= PERIOD_1)     hue_red = hue_u_s1 - PERIOD_1;
		else                               hue_red = hue_u_s1;
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			vs_s2    <= VS_W'(val_s1) * VS_W'(sat_s1);
			val_s2   <= val_s1;
			hue_r_s2 <= hue_red[R_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: round chroma, offset, sector and position in the sector.
	// ------------------------------------------------------------------
	chan_t          chroma_s3, offset_s3;
	logic [2:0]     sector_s3;
	logic [F_W-1:0] num_s3;

	logic [VS_W-1:0] vs_rnd;
	chan_t           chroma_raw, chroma;
	logic [2:0]      sector;
	logic [R_W-1:0]  pos;
	logic [F_W-1:0]  pos_f;

	assign vs_rnd     = vs_s2 + VS_HALF;
	assign chroma_raw = vs_rnd[CH_FRAC +: CH_W];
	assign chroma     = (chroma_raw > val_s2) ? val_s2 : chroma_raw;

	always_comb begin
		priority if (hue_r_s2 >= SPAN_5) begin
			sector = SECTOR_RED_BLUE;
			pos    = hue_r_s2 - SPAN_5;
		end else if (hue_r_s2 >= SPAN_4) begin
			sector = SECTOR_BLUE_RED;
			pos    = hue_r_s2 - SPAN_4;
		end else if (hue_r_s2 >= SPAN_3) begin
			sector = SECTOR_BLUE_GREEN;
			pos    = hue_r_s2 - SPAN_3;
		end else if (hue_r_s2 >= SPAN_2) begin
			sector = SECTOR_GREEN_BLUE;
			pos    = hue_r_s2 - SPAN_2;
		end else if (hue_r_s2 >= SPAN_1) begin
			sector = SECTOR_GREEN_RED;
			pos    = hue_r_s2 - SPAN_1;
		end else begin
			sector = SECTOR_RED_GREEN;
			pos    = hue_r_s2;
		end
	end

	assign pos_f = pos[F_W-1:0];

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			chroma_s3 <= chroma;
			offset_s3 <= val_s2 - chroma;
			sector_s3 <= sector;
			// Odd sectors fall from full chroma, even sectors rise.
			num_s3    <= sector[0] ? (SPAN_F - pos_f) : pos_f;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: C times the rising or falling position within the sector.
	// ------------------------------------------------------------------
	logic [CN_W-1:0] cn_s4;
	chan_t           chroma_s4, offset_s4;
	logic [2:0]      sector_s4;

	always_ff @(posedge clk) begin
		if (en_s4 && valid_s3) begin
			cn_s4     <= CN_W'(chroma_s3) * CN_W'(num_s3);
			chroma_s4 <= chroma_s3;
			offset_s4 <= offset_s3;
			sector_s4 <= sector_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: rounded division by the span, as a shift and a reciprocal.
	// ------------------------------------------------------------------
	logic [Q_W-1:0]  quot_s5;
	chan_t           chroma_s5, offset_s5;
	logic [2:0]      sector_s5;
	logic [CN_W-1:0] cn_rnd;
	logic [A_W-1:0]  cn_hi;

	assign cn_rnd = cn_s4 + SPAN_HALF;
	assign cn_hi  = cn_rnd[DIV_SHIFT +: A_W];

	always_ff @(posedge clk) begin
		if (en_s5 && valid_s4) begin
			quot_s5   <= Q_W'(cn_hi) * Q_W'(RECIP_15);
			chroma_s5 <= chroma_s4;
			offset_s5 <= offset_s4;
			sector_s5 <= sector_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: place C and X on the channels and add the offset.
	// ------------------------------------------------------------------
	chan_t red_s6, green_s6, blue_s6;
	chan_t sec_comp, red_b, green_b, blue_b;

	assign sec_comp = quot_s5[RECIP_SHIFT +: CH_W];

	always_comb begin
		unique case (sector_s5)
			SECTOR_RED_GREEN: begin
				red_b = chroma_s5; green_b = sec_comp; blue_b = '0;
			end
			SECTOR_GREEN_RED: begin
				red_b = sec_comp; green_b = chroma_s5; blue_b = '0;
			end
			SECTOR_GREEN_BLUE: begin
				red_b = '0; green_b = chroma_s5; blue_b = sec_comp;
			end
			SECTOR_BLUE_GREEN: begin
				red_b = '0; green_b = sec_comp; blue_b = chroma_s5;
			end
			SECTOR_BLUE_RED: begin
				red_b = sec_comp; green_b = '0; blue_b = chroma_s5;
			end
			default: begin
				red_b = chroma_s5; green_b = '0; blue_b = sec_comp;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s6 && valid_s5) begin
			red_s6   <= red_b + offset_s5;
			green_s6 <= green_b + offset_s5;
			blue_s6  <= blue_b + offset_s5;
		end
	end

	assign rgb.valid = valid_s6;
	assign rgb.red   = red_s6;
	assign rgb.green = green_s6;
	assign rgb.blue  = blue_s6;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	logic out_in_range;

	assign out_in_range = (red_s6 <= CH_ONE) && (green_s6 <= CH_ONE) && (blue_s6 <= CH_ONE);

	`HSV_ASSERT(a_chan_range, !valid_s6 || out_in_range, "channel above full scale")
	`HSV_ASSERT(a_sector_range, !valid_s3 || sector_s3 <= SECTOR_RED_BLUE, "bad sector code")
	`HSV_ASSERT_NEXT(a_stall_keeps, valid_s5 && !en_s6, valid_s5 && valid_s6, "stalled pixel lost")

endmodule

`default_nettype wire
